FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// edge of aclk and is switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent check.
`define BSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check that a condition in one cycle implies a result in the next cycle.
`define BSD_ASSERT_NEXT(lbl, cond, res, msg) \
    `BSD_ASSERT(lbl, (cond) |=> (res), msg)

`endif

FILE: src/bsd_pkg.sv
package bsd_pkg;

    // Sizing of the line store and the window.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 3;
    localparam int HEIGHT_MAX = 4096;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int HIST_W = 2 * MAX_RADIUS;
    localparam int TAPS   = 2 * MAX_RADIUS + 1;
    localparam int HM1_W  = $clog2(HEIGHT_MAX);
    // Rows keep counting past the frame while the last results drain.
    localparam int ROW_W  = $clog2(HEIGHT_MAX + MAX_RADIUS + 2);
    localparam int LAG_W  = $clog2(MAX_RADIUS * (MAX_WIDTH + 1) + 1);

    // Register field widths.
    localparam int RAD_W   = 2;
    localparam int WREG_W  = 11;
    localparam int HREG_W  = 13;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 13;

    // Register indexes.
    localparam logic [CIDX_W-1:0] CFG_RADIUS = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_WIDTH  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_HEIGHT = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_BORDER = 3'd3;

    // Input item kinds.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Reset values of the registers.
    localparam int WIDTH_RESET  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int HEIGHT_RESET = 1024;

    // Result queue.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    localparam logic [7:0] PIX_ON  = 8'd255;
    localparam logic [7:0] PIX_OFF = 8'd0;

    typedef struct packed {
        logic              en;
        logic [COL_W-1:0]  addr;
        logic [HIST_W-1:0] data;
    } ls_wr_t;

    typedef struct packed {
        logic fg;
        logic last;
    } oq_entry_t;

endpackage

FILE: src/binary_square_dilation.sv
// Channel  Direction  Handshake            Contents
// s_       in         s_tvalid / s_tready  tdata: pixel; tuser: opcode
// m_       out        m_tvalid / m_tready  tdata: out_pixel; tlast: frame_end
// cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel beat is taken per cycle while s_tready is high; a result passes
// the s1 and s2 stages and the result queue, limited by the line store read
// and the window stage. Once the last pixel of a frame is in, every beat
// yields one result; when the window lag exceeds the frame size, s_tready
// drops while the column pipeline steps through the padding positions alone.
// Reset is synchronous and needs no clearing pass: line store columns are
// only read for rows already written in the frame. A stall on m_ stops input
// only once queued and in-flight results together fill the four-entry queue.
`include "assert_macros.svh"

module binary_square_dilation import bsd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // Input beats.
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] pixel
    input  logic               s_tuser,    // [0] opcode
    // Result beats.
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,    // [7:0] out_pixel
    output logic               m_tlast,
    // Register writes.
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data
);

    // Registers, held as clamped effective values.
    logic [RAD_W-1:0] radius_reg, radius_next;
    logic [COL_W-1:0] w_m1_reg, w_m1_next;
    logic [HM1_W-1:0] h_m1_reg, h_m1_next;

    // Frame position counters.
    logic [COL_W-1:0] vcol_reg, vcol_next;
    logic [ROW_W-1:0] vrow_reg, vrow_next;
    logic [COL_W-1:0] ocol_reg, ocol_next;
    logic [HM1_W-1:0] orow_reg, orow_next;
    logic [LAG_W-1:0] lag_reg, lag_next;
    logic             credit_reg, credit_next;

    // Pipeline stage after issue.
    logic             s1_valid_reg;
    logic             s1_prod_reg;
    logic             s1_last_reg;
    logic             s1_bit_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [TAPS-1:0]  s1_mask_reg;

    // Pipeline stage after the column shift.
    logic s2_prod_reg;
    logic s2_last_reg;

    logic                cfg_we;
    logic [LAG_W-1:0]    d_val;
    logic                drain;
    logic                prod;
    logic                last_out;
    logic                space_ok;
    logic                step;
    logic                take_credit;
    logic                set_credit;
    logic                issue_last;
    logic                pix_bit;
    logic [TAPS-1:0]     vmask;
    logic [HIST_W-1:0]   ls_word;
    ls_wr_t              ls_wr;
    logic [TAPS-1:0]     col_vec;
    logic                col_or;
    logic                cell_bit [TAPS];
    logic [ROW_W-1:0]    cell_row [TAPS];
    logic [ROW_W-1:0]    center_row;
    logic                win_or;
    oq_entry_t           oq_in;
    oq_entry_t           oq_head;
    logic                oq_push;
    logic                oq_pop;
    logic [OQ_CNT_W-1:0] oq_count;
    logic [OQ_CNT_W:0]   pending;

    // Register writes are taken at any time; the border mode gives the same
    // window for a square kernel and only restarts the frame.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && (cfg_index <= CFG_BORDER);

    always_comb begin
        radius_next = radius_reg;
        w_m1_next   = w_m1_reg;
        h_m1_next   = h_m1_reg;
        if (cfg_valid && (cfg_index == CFG_RADIUS)) begin
            if (cfg_data[RAD_W-1:0] == '0) begin
                radius_next = RAD_W'(1);
            end else if (32'(cfg_data[RAD_W-1:0]) > MAX_RADIUS) begin
                radius_next = RAD_W'(MAX_RADIUS);
            end else begin
                radius_next = cfg_data[RAD_W-1:0];
            end
        end
        if (cfg_valid && (cfg_index == CFG_WIDTH)) begin
            if (cfg_data[WREG_W-1:0] == '0) begin
                w_m1_next = '0;
            end else if (32'(cfg_data[WREG_W-1:0]) > MAX_WIDTH) begin
                w_m1_next = COL_W'(MAX_WIDTH - 1);
            end else begin
                w_m1_next = COL_W'(cfg_data[WREG_W-1:0] - WREG_W'(1));
            end
        end
        if (cfg_valid && (cfg_index == CFG_HEIGHT)) begin
            if (cfg_data[HREG_W-1:0] == '0) begin
                h_m1_next = '0;
            end else if (32'(cfg_data[HREG_W-1:0]) > HEIGHT_MAX) begin
                h_m1_next = HM1_W'(HEIGHT_MAX - 1);
            end else begin
                h_m1_next = HM1_W'(cfg_data[HREG_W-1:0] - HREG_W'(1));
            end
        end
    end

    // Lag between the newest pixel and the result it completes: R*W + R.
    assign d_val = (LAG_W'(w_m1_reg) + LAG_W'(2)) * LAG_W'(radius_reg);

    // Issue decision for one column step.
    assign drain    = (vrow_reg > ROW_W'(h_m1_reg));
    assign prod     = (lag_reg >= d_val);
    assign last_out = (orow_reg == h_m1_reg) && (ocol_reg == w_m1_reg);
    assign pending  = (OQ_CNT_W + 1)'(oq_count) + (OQ_CNT_W + 1)'(s1_prod_reg)
                    + (OQ_CNT_W + 1)'(s2_prod_reg);
    assign space_ok = (pending < (OQ_CNT_W + 1)'(OQ_DEPTH));

    always_comb begin
        if (drain) begin
            s_tready    = prod && space_ok && !credit_reg;
            take_credit = prod && space_ok && credit_reg;
            step        = prod ? (space_ok && (credit_reg || s_tvalid)) : 1'b1;
        end else begin
            s_tready    = !prod || space_ok;
            take_credit = 1'b0;
            step        = s_tvalid && s_tready && (s_tuser == OP_PIXEL);
        end
    end

    // The last pixel of a frame owes one result when it produces none itself.
    assign set_credit = step && !drain && !prod
                      && (vcol_reg == w_m1_reg) && (vrow_reg == ROW_W'(h_m1_reg));
    assign issue_last = step && prod && last_out;
    assign pix_bit    = !drain && (s_tdata != '0);

    // Rows of the column that lie inside the frame and inside the kernel.
    always_comb begin
        for (int j = 0; j < TAPS; j++) begin
            vmask[j] = (j <= 2 * int'(radius_reg))
                     && (vrow_reg >= ROW_W'(j))
                     && ((vrow_reg - ROW_W'(j)) <= ROW_W'(h_m1_reg));
        end
    end

    // Counter updates; a register write or the last result restarts the frame.
    always_comb begin
        vcol_next   = vcol_reg;
        vrow_next   = vrow_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        lag_next    = lag_reg;
        credit_next = credit_reg;
        if (cfg_we || issue_last) begin
            vcol_next   = '0;
            vrow_next   = '0;
            ocol_next   = '0;
            orow_next   = '0;
            lag_next    = '0;
            credit_next = 1'b0;
        end else if (step) begin
            if (vcol_reg == w_m1_reg) begin
                vcol_next = '0;
                vrow_next = vrow_reg + ROW_W'(1);
            end else begin
                vcol_next = vcol_reg + COL_W'(1);
            end
            if (prod) begin
                if (ocol_reg == w_m1_reg) begin
                    ocol_next = '0;
                    orow_next = orow_reg + HM1_W'(1);
                end else begin
                    ocol_next = ocol_reg + COL_W'(1);
                end
            end else begin
                lag_next = lag_reg + LAG_W'(1);
            end
            if (take_credit) begin
                credit_next = 1'b0;
            end else if (set_credit) begin
                credit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= RAD_W'(1);
            w_m1_reg     <= COL_W'(WIDTH_RESET - 1);
            h_m1_reg     <= HM1_W'(HEIGHT_RESET - 1);
            vcol_reg     <= '0;
            vrow_reg     <= '0;
            ocol_reg     <= '0;
            orow_reg     <= '0;
            lag_reg      <= '0;
            credit_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_prod_reg  <= 1'b0;
            s2_prod_reg  <= 1'b0;
        end else begin
            radius_reg   <= radius_next;
            w_m1_reg     <= w_m1_next;
            h_m1_reg     <= h_m1_next;
            vcol_reg     <= vcol_next;
            vrow_reg     <= vrow_next;
            ocol_reg     <= ocol_next;
            orow_reg     <= orow_next;
            lag_reg      <= lag_next;
            credit_reg   <= credit_next;
            s1_valid_reg <= step;
            s1_prod_reg  <= step && prod;
            s2_prod_reg  <= s1_valid_reg && s1_prod_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        s1_last_reg <= last_out;
        s1_bit_reg  <= pix_bit;
        s1_addr_reg <= vcol_reg;
        s1_row_reg  <= vrow_reg;
        s1_mask_reg <= vmask;
        s2_last_reg <= s1_last_reg;
    end

    // Column history, one word per column.
    bsd_linestore u_linestore (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (vcol_reg),
        .wr      (ls_wr),
        .rd_word (ls_word)
    );

    // Vertical OR of the column and the shifted history written back.
    assign col_vec  = {ls_word, s1_bit_reg};
    assign col_or   = |(col_vec & s1_mask_reg);
    assign ls_wr.en   = s1_valid_reg;
    assign ls_wr.addr = s1_addr_reg;
    assign ls_wr.data = {ls_word[HIST_W-2:0], s1_bit_reg};

    // Row of cells holding the column ORs of the window, newest first.
    for (genvar a = 0; a < TAPS; a++) begin : g_cell
        if (a == 0) begin : g_head
            bsd_cell u_cell (
                .aclk     (aclk),
                .shift_en (s1_valid_reg),
                .in_bit   (col_or),
                .in_row   (s1_row_reg),
                .out_bit  (cell_bit[a]),
                .out_row  (cell_row[a])
            );
        end else begin : g_body
            bsd_cell u_cell (
                .aclk     (aclk),
                .shift_en (s1_valid_reg),
                .in_bit   (cell_bit[a-1]),
                .in_row   (cell_row[a-1]),
                .out_bit  (cell_bit[a]),
                .out_row  (cell_row[a])
            );
        end
    end

    // Horizontal OR over the columns that share the row of the center column.
    always_comb begin
        center_row = cell_row[0];
        for (int a = 0; a < TAPS; a++) begin
            if (a == int'(radius_reg)) begin
                center_row = cell_row[a];
            end
        end
        win_or = 1'b0;
        for (int a = 0; a < TAPS; a++) begin
            if ((a <= 2 * int'(radius_reg)) && cell_bit[a] && (cell_row[a] == center_row)) begin
                win_or = 1'b1;
            end
        end
    end

    assign oq_push    = s2_prod_reg;
    assign oq_in.fg   = win_or;
    assign oq_in.last = s2_last_reg;
    assign oq_pop     = m_tready;

    // Results wait here while the output side stalls.
    bsd_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (oq_push),
        .push_data  (oq_in),
        .pop        (oq_pop),
        .head_valid (m_tvalid),
        .head       (oq_head),
        .count      (oq_count)
    );

    assign m_tdata = oq_head.fg ? PIX_ON : PIX_OFF;
    assign m_tlast = oq_head.last;

    `BSD_ASSERT(a_credit_in_drain, credit_reg |-> drain, "owed result outside drain")
    `BSD_ASSERT(a_queue_room, oq_push |-> (oq_count < OQ_CNT_W'(OQ_DEPTH)), "result queue overrun")
    `BSD_ASSERT_NEXT(a_last_restart, issue_last, (vrow_reg == '0) && (lag_reg == '0), "no restart")
    `BSD_ASSERT(a_no_take_in_catchup, (drain && !prod) |-> !s_tready, "beat taken in catch-up")

endmodule

FILE: src/bsd_cell.sv
module bsd_cell import bsd_pkg::*; (
    input  logic             aclk,
    input  logic             shift_en,
    input  logic             in_bit,
    input  logic [ROW_W-1:0] in_row,
    output logic             out_bit,
    output logic [ROW_W-1:0] out_row
);

    logic             bit_reg;
    logic [ROW_W-1:0] row_reg;

    // One column of the window: its vertical OR and the row it came from.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            bit_reg <= in_bit;
            row_reg <= in_row;
        end
    end

    assign out_bit = bit_reg;
    assign out_row = row_reg;

endmodule

FILE: src/bsd_linestore.sv
module bsd_linestore import bsd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [COL_W-1:0]  rd_addr,
    input  ls_wr_t            wr,
    output logic [HIST_W-1:0] rd_word
);

    logic [HIST_W-1:0] mem [MAX_WIDTH];
    logic [HIST_W-1:0] rd_data_reg;
    logic [HIST_W-1:0] fwd_data_reg;
    logic              fwd_reg;

    // Column history: bit j holds the pixel j+1 rows above.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg  <= mem[rd_addr];
        fwd_data_reg <= wr.data;
    end

    // A read of the column being written in the same cycle takes the new word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else begin
            fwd_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    assign rd_word = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

FILE: src/bsd_outq.sv
module bsd_outq import bsd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  oq_entry_t           push_data,
    input  logic                pop,
    output logic                head_valid,
    output oq_entry_t           head,
    output logic [OQ_CNT_W-1:0] count
);

    oq_entry_t           entry_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg;
    logic [OQ_PTR_W-1:0] rd_ptr_reg;
    logic [OQ_CNT_W-1:0] cnt_reg;
    logic [OQ_CNT_W-1:0] cnt_next;
    logic                do_pop;

    assign do_pop = pop && (cnt_reg != '0);

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !do_pop) begin
            cnt_next = cnt_reg + OQ_CNT_W'(1);
        end else if (!push && do_pop) begin
            cnt_next = cnt_reg - OQ_CNT_W'(1);
        end
    end

    // Storage of waiting results.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + OQ_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + OQ_PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    assign head_valid = (cnt_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign count      = cnt_reg;

endmodule
